@@ rtl/csetp_pkg.sv @@
// shared constants, codes and controller/datapath interface types for the profiler
package csetp_pkg;

    localparam int DEF_NUM_FUNCS   = 1024;
    localparam int DEF_STACK_DEPTH = 64;
    localparam int TIME_BITS       = 48;
    localparam int ID_BITS         = 10;
    localparam int OP_BITS         = 2;
    localparam int STATUS_BITS     = 2;
    localparam int COUNT_BITS      = 32;

    localparam logic [OP_BITS-1:0] OP_START = OP_BITS'(0);
    localparam logic [OP_BITS-1:0] OP_END   = OP_BITS'(1);
    localparam logic [OP_BITS-1:0] OP_READ  = OP_BITS'(2);

    localparam logic [STATUS_BITS-1:0] ST_OK       = STATUS_BITS'(0);
    localparam logic [STATUS_BITS-1:0] ST_MISMATCH = STATUS_BITS'(1);
    localparam logic [STATUS_BITS-1:0] ST_EMPTY    = STATUS_BITS'(2);
    localparam logic [STATUS_BITS-1:0] ST_FULL     = STATUS_BITS'(3);

    typedef struct packed {
        logic                   load;
        logic                   reduce;
        logic                   clr_wr;
        logic                   rd_stats;
        logic                   rd_starts;
        logic                   addr_caller;
        logic                   wr_charge;
        logic                   wr_callee;
        logic                   pop;
        logic                   rd_below;
        logic                   set_top;
        logic                   res_rd;
        logic                   res_charge;
        logic                   res_callee;
        logic                   status_load;
        logic [STATUS_BITS-1:0] status_code;
        logic                   out_load;
    } cmd_t;

    typedef struct packed {
        logic [OP_BITS-1:0] op;
        logic               full;
        logic               empty;
        logic               mismatch;
        logic               has_below;
        logic               clr_last;
        logic               out_free;
    } sts_t;

endpackage

@@ rtl/csetp_ram.sv @@
// generic single-write, single-read ram with registered read data
module csetp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = data_reg;

endmodule

@@ rtl/csetp_dp.sv @@
// profiler datapath: id reduction, table and stack memories, charge arithmetic, result register
module csetp_dp
    import csetp_pkg::*;
#(
    parameter int NUM_FUNCS   = DEF_NUM_FUNCS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cmd_t                   cmd,
    output sts_t                   sts,
    input  logic [OP_BITS-1:0]     opcode,
    input  logic [ID_BITS-1:0]     func_id,
    input  logic [TIME_BITS-1:0]   timestamp,
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic [STATUS_BITS-1:0] status,
    output logic [ID_BITS-1:0]     func_out,
    output logic [TIME_BITS-1:0]   exclusive_total,
    output logic [TIME_BITS-1:0]   inclusive_last,
    output logic [COUNT_BITS-1:0]  call_count
);

    localparam int     FA = $clog2(NUM_FUNCS);
    localparam int     SA = $clog2(STACK_DEPTH);
    localparam int     LW = $clog2(STACK_DEPTH + 1);
    localparam int     SW = 2 * TIME_BITS + COUNT_BITS;
    localparam int     RK = ID_BITS + $clog2(NUM_FUNCS);
    localparam longint RM = ((longint'(1) << RK) + longint'(NUM_FUNCS) - 1)
                            / longint'(NUM_FUNCS);
    localparam int     PW = 2 * ID_BITS + 2;

    logic [OP_BITS-1:0]     op_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic [TIME_BITS-1:0]   ts_reg;
    logic [ID_BITS-1:0]     rem_reg, rem_next;
    logic [FA-1:0]          clr_reg;
    logic [LW-1:0]          level_reg, level_next;
    logic [FA-1:0]          top_reg;
    logic [STATUS_BITS-1:0] status_reg;
    logic [TIME_BITS-1:0]   res_sum_reg, res_incl_reg;
    logic [COUNT_BITS-1:0]  res_calls_reg;
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic [ID_BITS-1:0]     out_func_reg;
    logic [TIME_BITS-1:0]   out_excl_reg, out_incl_reg;
    logic [COUNT_BITS-1:0]  out_calls_reg;

    logic [FA-1:0]          f;
    logic [FA-1:0]          tbl_addr;
    logic [PW-1:0]          rprod;
    logic [ID_BITS-1:0]     rquot;
    logic [LW-1:0]          below;

    logic [SW-1:0]          stats_rd, stats_wr;
    logic [TIME_BITS-1:0]   sum_rd, incl_rd, xs_rd, is_rd;
    logic [COUNT_BITS-1:0]  calls_rd, calls_inc;
    logic [TIME_BITS-1:0]   el_x, incl_new, sum_new;
    logic [TIME_BITS:0]     sum_wide;
    logic [FA-1:0]          stack_rd;
    logic                   stats_we, xs_we;
    logic [FA-1:0]          stats_waddr, xs_waddr;

    assign f        = FA'(rem_reg);
    assign tbl_addr = cmd.addr_caller ? top_reg : f;
    assign below    = level_reg - LW'(2);

    // id modulo the table size by reciprocal multiplication, exact for every id value
    assign rprod = PW'(rem_reg) * PW'(RM);
    assign rquot = ID_BITS'(rprod >> RK);

    always_comb
    begin
        rem_next = rem_reg;
        if (cmd.load)
        begin
            rem_next = func_id;
        end
        else if (cmd.reduce)
        begin
            rem_next = rem_reg - ID_BITS'(rquot * NUM_FUNCS);
        end
    end

    assign sum_rd   = stats_rd[SW-1 -: TIME_BITS];
    assign incl_rd  = stats_rd[TIME_BITS+COUNT_BITS-1 -: TIME_BITS];
    assign calls_rd = stats_rd[COUNT_BITS-1:0];

    assign el_x      = ts_reg - xs_rd;
    assign incl_new  = ts_reg - is_rd;
    assign sum_wide  = {1'b0, sum_rd} + {1'b0, el_x};
    assign sum_new   = sum_wide[TIME_BITS] ? '1 : sum_wide[TIME_BITS-1:0];
    assign calls_inc = (calls_rd == '1) ? calls_rd : calls_rd + COUNT_BITS'(1);

    always_comb
    begin
        if (cmd.clr_wr)
        begin
            stats_wr = '0;
        end
        else if (cmd.wr_charge)
        begin
            stats_wr = {sum_new, incl_new, calls_rd};
        end
        else
        begin
            stats_wr = {sum_rd, incl_rd, calls_inc};
        end
    end

    assign stats_we    = cmd.clr_wr | cmd.wr_charge | cmd.wr_callee;
    assign stats_waddr = cmd.clr_wr ? clr_reg : tbl_addr;
    assign xs_we       = cmd.wr_callee | cmd.set_top;
    // on a return the caller's exclusive clock restarts at the popped-to entry
    assign xs_waddr    = cmd.set_top ? stack_rd : f;

    csetp_ram #(.WIDTH(SW), .DEPTH(NUM_FUNCS)) u_stats (
        .clk     (clk),
        .wr_en   (stats_we),
        .wr_addr (stats_waddr),
        .wr_data (stats_wr),
        .rd_en   (cmd.rd_stats),
        .rd_addr (tbl_addr),
        .rd_data (stats_rd)
    );

    csetp_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_FUNCS)) u_xstart (
        .clk     (clk),
        .wr_en   (xs_we),
        .wr_addr (xs_waddr),
        .wr_data (ts_reg),
        .rd_en   (cmd.rd_starts),
        .rd_addr (tbl_addr),
        .rd_data (xs_rd)
    );

    csetp_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_FUNCS)) u_istart (
        .clk     (clk),
        .wr_en   (cmd.wr_callee),
        .wr_addr (f),
        .wr_data (ts_reg),
        .rd_en   (cmd.rd_starts),
        .rd_addr (tbl_addr),
        .rd_data (is_rd)
    );

    csetp_ram #(.WIDTH(FA), .DEPTH(STACK_DEPTH)) u_stack (
        .clk     (clk),
        .wr_en   (cmd.wr_callee),
        .wr_addr (SA'(level_reg)),
        .wr_data (f),
        .rd_en   (cmd.rd_below),
        .rd_addr (SA'(below)),
        .rd_data (stack_rd)
    );

    always_comb
    begin
        level_next = level_reg;
        if (cmd.wr_callee)
        begin
            level_next = level_reg + LW'(1);
        end
        else if (cmd.pop)
        begin
            level_next = level_reg - LW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg & res_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_reg <= clr_reg + FA'(1);
            end
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            op_reg <= opcode;
            id_reg <= func_id;
            ts_reg <= timestamp;
        end
        if (cmd.wr_callee)
        begin
            top_reg <= f;
        end
        else if (cmd.set_top)
        begin
            top_reg <= stack_rd;
        end
        if (cmd.status_load)
        begin
            status_reg <= cmd.status_code;
        end
        if (cmd.res_rd)
        begin
            res_sum_reg   <= sum_rd;
            res_incl_reg  <= incl_rd;
            res_calls_reg <= calls_rd;
        end
        else if (cmd.res_charge)
        begin
            res_sum_reg   <= sum_new;
            res_incl_reg  <= incl_new;
            res_calls_reg <= calls_rd;
        end
        else if (cmd.res_callee)
        begin
            res_sum_reg   <= sum_rd;
            res_incl_reg  <= incl_rd;
            res_calls_reg <= calls_inc;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= status_reg;
            out_func_reg   <= id_reg;
            out_excl_reg   <= res_sum_reg;
            out_incl_reg   <= res_incl_reg;
            out_calls_reg  <= res_calls_reg;
        end
    end

    assign sts.op          = op_reg;
    assign sts.full        = (level_reg == LW'(STACK_DEPTH));
    assign sts.empty       = (level_reg == '0);
    assign sts.mismatch    = (top_reg != f);
    assign sts.has_below   = (level_reg > LW'(1));
    assign sts.clr_last    = (clr_reg == FA'(NUM_FUNCS - 1));
    assign sts.out_free    = !out_valid_reg || !res_stall;

    assign res_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign func_out        = out_func_reg;
    assign exclusive_total = out_excl_reg;
    assign inclusive_last  = out_incl_reg;
    assign call_count      = out_calls_reg;

endmodule

@@ rtl/csetp_ctrl.sv @@
// profiler controller: sequences table clearing and the memory steps of each event
module csetp_ctrl
    import csetp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic evt_valid,
    output logic evt_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_DISPATCH,
        S_CALLER_CHG,
        S_CALLEE_RD,
        S_CALLEE_UPD,
        S_END_CHG,
        S_END_TOP,
        S_RD_RES,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (evt_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                cmd.status_load = 1'b1;
                cmd.status_code = ST_OK;
                cmd.rd_stats    = 1'b1;
                case (sts.op)
                    OP_START:
                    begin
                        if (sts.full)
                        begin
                            cmd.status_code = ST_FULL;
                            state_next      = S_RD_RES;
                        end
                        else if (!sts.empty)
                        begin
                            // caller gets charged first
                            cmd.rd_starts   = 1'b1;
                            cmd.addr_caller = 1'b1;
                            state_next      = S_CALLER_CHG;
                        end
                        else
                        begin
                            state_next = S_CALLEE_UPD;
                        end
                    end
                    OP_END:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status_code = ST_EMPTY;
                            state_next      = S_RD_RES;
                        end
                        else if (sts.mismatch)
                        begin
                            cmd.status_code = ST_MISMATCH;
                            state_next      = S_RD_RES;
                        end
                        else
                        begin
                            cmd.rd_starts = 1'b1;
                            state_next    = S_END_CHG;
                        end
                    end
                    default:
                    begin
                        state_next = S_RD_RES;
                    end
                endcase
            end
            S_CALLER_CHG:
            begin
                cmd.wr_charge   = 1'b1;
                cmd.addr_caller = 1'b1;
                state_next      = S_CALLEE_RD;
            end
            S_CALLEE_RD:
            begin
                // separate cycle so a recursive call sees the charged entry
                cmd.rd_stats = 1'b1;
                state_next   = S_CALLEE_UPD;
            end
            S_CALLEE_UPD:
            begin
                cmd.wr_callee  = 1'b1;
                cmd.res_callee = 1'b1;
                state_next     = S_DONE;
            end
            S_END_CHG:
            begin
                cmd.wr_charge  = 1'b1;
                cmd.res_charge = 1'b1;
                cmd.pop        = 1'b1;
                if (sts.has_below)
                begin
                    cmd.rd_below = 1'b1;
                    state_next   = S_END_TOP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_END_TOP:
            begin
                cmd.set_top = 1'b1;
                state_next  = S_DONE;
            end
            S_RD_RES:
            begin
                cmd.res_rd = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign evt_stall = (state_reg != S_IDLE);

endmodule

@@ rtl/call_stack_exclusive_time_profiler_top.sv @@
// call stack exclusive time profiler top level
//
//  channel  valid      stall      beat contents
//  event    evt_valid  evt_stall  opcode, func_id, timestamp
//  result   res_valid  res_stall  status, func_out, exclusive_total, inclusive_last, call_count
//
// one event at a time: each event is loaded, reduced, dispatched and taken through its memory steps,
// paced by the single read and write port of each table memory
// the reduce step folds the id into the table range with a reciprocal multiply
// after reset a clearing pass zeroes the statistics table, evt_stall high
// a finished beat waits in the result register while the next event is taken in
// a result still stalled when the next one is ready holds the controller until it leaves
module call_stack_exclusive_time_profiler_top
    import csetp_pkg::*;
#(
    parameter int NUM_FUNCS   = DEF_NUM_FUNCS,
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   evt_valid,
    output logic                   evt_stall,
    input  logic [OP_BITS-1:0]     opcode,
    input  logic [ID_BITS-1:0]     func_id,
    input  logic [TIME_BITS-1:0]   timestamp,
    output logic                   res_valid,
    input  logic                   res_stall,
    output logic [STATUS_BITS-1:0] status,
    output logic [ID_BITS-1:0]     func_out,
    output logic [TIME_BITS-1:0]   exclusive_total,
    output logic [TIME_BITS-1:0]   inclusive_last,
    output logic [COUNT_BITS-1:0]  call_count
);

    cmd_t cmd;
    sts_t sts;

    csetp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    csetp_dp #(
        .NUM_FUNCS   (NUM_FUNCS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .opcode          (opcode),
        .func_id         (func_id),
        .timestamp       (timestamp),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .status          (status),
        .func_out        (func_out),
        .exclusive_total (exclusive_total),
        .inclusive_last  (inclusive_last),
        .call_count      (call_count)
    );

endmodule
